/* design/multiword_schoolbook_multiply_assert.svh */
// assertion macros for the multiword schoolbook multiplier
// used by the rtl files that carry assertions, no other dependencies
`ifndef MULTIWORD_SCHOOLBOOK_MULTIPLY_ASSERT_SVH
`define MULTIWORD_SCHOOLBOOK_MULTIPLY_ASSERT_SVH
`ifndef SYNTHESIS
`define MSM_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define MSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MSM_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define MSM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* design/msm_pkg.sv */
// shared types and constants for the multiword schoolbook multiplier
// no dependencies
`default_nettype none
package msm_pkg;
    localparam int MAX_LIMBS_DEF = 32;
    localparam int LIMB_W        = 64;
    localparam int HALF_W        = 32;
    localparam int LEN_W         = 6;
    localparam int ADDR_MAX_W    = 5;
    localparam int QDEPTH        = 2;

    typedef struct packed {
        logic [LEN_W-1:0] xl;
        logic [LEN_W-1:0] yl;
        logic             ovf;
        logic             zero;
    } job_t;

    typedef struct packed {
        logic [ADDR_MAX_W-1:0] x_addr;
        logic [ADDR_MAX_W-1:0] y_addr;
    } rd_req_t;

    typedef struct packed {
        logic idle;
    } back_status_t;
endpackage
`default_nettype wire

/* design/multiword_schoolbook_multiply.sv */
// Multiword schoolbook multiplier, 64-bit limbs, least significant limb first.
// Operand limbs are taken one beat per cycle; a beat with cmd 1 and last set
// starts the product. The block then stops taking beats until the whole
// product has been delivered. The back end clears xl+yl product entries (one
// per cycle), then forms each of the xl*yl 64x64 limb products from four
// quarter products on a single 32x32 multiplier, and writes the top carry
// limb of each row. Each result beat then passes through the product store
// read port and the output register. An empty or single zero operand gives
// one zero beat right away. Limbs past MAX_LIMBS are dropped and overflow is
// set on every beat of that product.
// depends on msm_pkg, msm_front, msm_queue, msm_back
`default_nettype none
module multiword_schoolbook_multiply import msm_pkg::*; #(
    parameter int MAX_LIMBS = MAX_LIMBS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_cmd,
    input  wire logic [LIMB_W-1:0] s_limb,
    input  wire logic              s_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [LIMB_W-1:0]      m_product_limb,
    output logic                   m_last_res,
    output logic                   m_overflow
);
    // front to queue
    logic         job_push;
    job_t         job;
    // queue to back
    logic         q_valid, q_empty, pop;
    job_t         head;
    // back to front: status and operand read addresses
    back_status_t back_st;
    rd_req_t      rd_req;
    logic [LIMB_W-1:0] x_rd, y_rd;

    msm_front #(.MAX_LIMBS(MAX_LIMBS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_limb   (s_limb),
        .s_last   (s_last),
        .q_empty  (q_empty),
        .back_st  (back_st),
        .job_push (job_push),
        .job      (job),
        .rd_req   (rd_req),
        .x_rd     (x_rd),
        .y_rd     (y_rd)
    );

    msm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_empty  (q_empty),
        .head     (head)
    );

    msm_back #(.MAX_LIMBS(MAX_LIMBS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (pop),
        .back_st        (back_st),
        .rd_req         (rd_req),
        .x_rd           (x_rd),
        .y_rd           (y_rd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_product_limb (m_product_limb),
        .m_last_res     (m_last_res),
        .m_overflow     (m_overflow)
    );
endmodule
`default_nettype wire

/* design/msm_front.sv */
// front part: takes limb beats, fills the operand stores, hands out jobs
// depends on msm_pkg
`default_nettype none
module msm_front import msm_pkg::*; #(
    parameter int MAX_LIMBS = MAX_LIMBS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_cmd,
    input  wire logic [LIMB_W-1:0] s_limb,
    input  wire logic              s_last,
    input  wire logic              q_empty,
    input  wire back_status_t      back_st,
    output logic                   job_push,
    output job_t                   job,
    input  wire rd_req_t           rd_req,
    output logic [LIMB_W-1:0]      x_rd,
    output logic [LIMB_W-1:0]      y_rd
);
    localparam int AW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

    logic [LIMB_W-1:0] x_mem [MAX_LIMBS];
    logic [LIMB_W-1:0] y_mem [MAX_LIMBS];
    logic [LEN_W-1:0]  x_len_reg, y_len_reg, x_len_next, y_len_next;
    logic              x_closed_reg, y_closed_reg, x_closed_next, y_closed_next;
    logic              ovf_reg, ovf_next;
    logic              x0z_reg, y0z_reg, x0z_next, y0z_next;
    logic              acc;
    logic [LEN_W-1:0]  cur_len, new_len;
    logic              fits, y0z_eff;

    assign s_ready = q_empty && back_st.idle;
    assign acc     = s_valid && s_ready;

    always_comb begin
        if (s_cmd) begin
            cur_len = y_closed_reg ? '0 : y_len_reg;
        end else begin
            cur_len = x_closed_reg ? '0 : x_len_reg;
        end
        fits    = cur_len < LEN_W'(MAX_LIMBS);
        new_len = fits ? cur_len + LEN_W'(1) : cur_len;
        y0z_eff = (fits && cur_len == '0) ? (s_limb == '0) : y0z_reg;

        x_len_next    = x_len_reg;
        y_len_next    = y_len_reg;
        x_closed_next = x_closed_reg;
        y_closed_next = y_closed_reg;
        ovf_next      = ovf_reg;
        x0z_next      = x0z_reg;
        y0z_next      = y0z_reg;
        job_push      = 1'b0;
        job.xl        = x_len_reg;
        job.yl        = new_len;
        job.ovf       = ovf_reg || !fits;
        job.zero      = (x_len_reg == '0) || (new_len == '0)
                     || (x_len_reg == LEN_W'(1) && x0z_reg)
                     || (new_len == LEN_W'(1) && y0z_eff);
        if (acc) begin
            ovf_next = ovf_reg || !fits;
            if (!s_cmd) begin
                x_len_next    = new_len;
                x_closed_next = s_last;
                if (fits && cur_len == '0) begin
                    x0z_next = (s_limb == '0);
                end
            end else begin
                y_len_next    = new_len;
                y_closed_next = s_last;
                y0z_next      = y0z_eff;
                if (s_last) begin
                    // product starts, front returns to empty operands
                    job_push      = 1'b1;
                    x_len_next    = '0;
                    y_len_next    = '0;
                    x_closed_next = 1'b0;
                    y_closed_next = 1'b0;
                    ovf_next      = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_len_reg    <= '0;
            y_len_reg    <= '0;
            x_closed_reg <= 1'b0;
            y_closed_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            x0z_reg      <= 1'b0;
            y0z_reg      <= 1'b0;
        end else begin
            x_len_reg    <= x_len_next;
            y_len_reg    <= y_len_next;
            x_closed_reg <= x_closed_next;
            y_closed_reg <= y_closed_next;
            ovf_reg      <= ovf_next;
            x0z_reg      <= x0z_next;
            y0z_reg      <= y0z_next;
        end
    end

    // operand stores, one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (acc && fits && !s_cmd) begin
            x_mem[cur_len[AW-1:0]] <= s_limb;
        end
        if (acc && fits && s_cmd) begin
            y_mem[cur_len[AW-1:0]] <= s_limb;
        end
        x_rd <= x_mem[rd_req.x_addr[AW-1:0]];
        y_rd <= y_mem[rd_req.y_addr[AW-1:0]];
    end
endmodule
`default_nettype wire

/* design/msm_queue.sv */
// short job queue between front and back
// depends on msm_pkg
`default_nettype none
module msm_queue import msm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      q_valid,
    output logic      q_empty,
    output job_t      head
);
    localparam int PW = $clog2(QDEPTH);

    job_t            ent_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     cnt_reg, cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign q_valid = !q_empty;
    assign head    = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (PW+1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

/* design/msm_back.sv */
// back part: clears the product store, runs the limb products, emits the result
// depends on msm_pkg and the assertion macro header
`include "multiword_schoolbook_multiply_assert.svh"
`default_nettype none
module msm_back import msm_pkg::*; #(
    parameter int MAX_LIMBS = MAX_LIMBS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire job_t              head,
    output logic                   pop,
    output back_status_t           back_st,
    output rd_req_t                rd_req,
    input  wire logic [LIMB_W-1:0] x_rd,
    input  wire logic [LIMB_W-1:0] y_rd,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [LIMB_W-1:0]      m_product_limb,
    output logic                   m_last_res,
    output logic                   m_overflow
);
    localparam int PDEPTH = 2 * MAX_LIMBS;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int KW     = LEN_W + 1;
    localparam int ACC_W  = 2 * LIMB_W;

    typedef enum logic [2:0] {IDLE, CLR, MUL, TOP, ERD, EWT, EOUT} state_t;

    state_t             state_reg;
    job_t               job_reg;
    logic [LEN_W-1:0]   i_reg, j_reg;
    logic [KW-1:0]      k_reg, zl_reg, tot;
    logic [2:0]         ph_reg;
    logic [LIMB_W-1:0]  carry_reg;
    logic [ACC_W-1:0]   acc_reg, acc_add;
    logic [LIMB_W-1:0]  prod_reg, prod_c;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [LIMB_W-1:0]  p_mem [PDEPTH];
    logic [LIMB_W-1:0]  pd;
    logic [KW-1:0]      p_raddr, p_waddr;
    logic [LIMB_W-1:0]  p_wdata;
    logic               p_we;
    logic [KW-1:0]      ij;

    assign back_st.idle   = (state_reg == IDLE);
    assign pop            = q_valid && (state_reg == IDLE);
    assign rd_req.x_addr  = i_reg[ADDR_MAX_W-1:0];
    assign rd_req.y_addr  = j_reg[ADDR_MAX_W-1:0];
    assign tot            = KW'(job_reg.xl) + KW'(job_reg.yl);
    assign ij             = KW'(i_reg) + KW'(j_reg);
    assign p_raddr        = (state_reg == MUL) ? ij : k_reg;

    // quarter products: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        case (ph_reg)
            3'd1: begin mul_a = x_rd[HALF_W-1:0];      mul_b = y_rd[HALF_W-1:0];      end
            3'd2: begin mul_a = x_rd[HALF_W-1:0];      mul_b = y_rd[LIMB_W-1:HALF_W]; end
            3'd3: begin mul_a = x_rd[LIMB_W-1:HALF_W]; mul_b = y_rd[HALF_W-1:0];      end
            default: begin
                mul_a = x_rd[LIMB_W-1:HALF_W];
                mul_b = y_rd[LIMB_W-1:HALF_W];
            end
        endcase
    end
    assign prod_c = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

    always_comb begin
        case (ph_reg)
            3'd2:    acc_add = {{LIMB_W{1'b0}}, prod_reg};
            3'd5:    acc_add = {prod_reg, {LIMB_W{1'b0}}};
            default: acc_add = {{HALF_W{1'b0}}, prod_reg, {HALF_W{1'b0}}};
        endcase
    end

    // product store write port
    always_comb begin
        p_we    = 1'b0;
        p_waddr = k_reg;
        p_wdata = '0;
        case (state_reg)
            CLR: begin
                p_we = 1'b1;
            end
            MUL: begin
                p_we    = (ph_reg == 3'd6);
                p_waddr = ij;
                p_wdata = acc_reg[LIMB_W-1:0];
            end
            TOP: begin
                p_we    = 1'b1;
                p_waddr = KW'(job_reg.xl) + KW'(j_reg);
                p_wdata = carry_reg;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_mem[p_waddr[PAW-1:0]] <= p_wdata;
        end
        pd <= p_mem[p_raddr[PAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            m_valid   <= 1'b0;
            ph_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (q_valid) begin
                        job_reg <= head;
                        k_reg   <= '0;
                        i_reg   <= '0;
                        j_reg   <= '0;
                        ph_reg  <= '0;
                        if (head.zero) begin
                            m_product_limb <= '0;
                            m_last_res     <= 1'b1;
                            m_overflow     <= head.ovf;
                            m_valid        <= 1'b1;
                            zl_reg         <= KW'(1);
                            state_reg      <= EOUT;
                        end else begin
                            state_reg <= CLR;
                        end
                    end
                end
                CLR: begin
                    k_reg <= k_reg + KW'(1);
                    if (k_reg == tot - KW'(1)) begin
                        carry_reg <= '0;
                        state_reg <= MUL;
                    end
                end
                MUL: begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg != 3'd0) begin
                        prod_reg <= prod_c;
                    end
                    if (ph_reg == 3'd1) begin
                        acc_reg <= {{LIMB_W{1'b0}}, pd} + {{LIMB_W{1'b0}}, carry_reg};
                    end else if (ph_reg >= 3'd2 && ph_reg <= 3'd5) begin
                        acc_reg <= acc_reg + acc_add;
                    end
                    if (ph_reg == 3'd6) begin
                        ph_reg    <= '0;
                        carry_reg <= acc_reg[ACC_W-1:LIMB_W];
                        if (i_reg == job_reg.xl - LEN_W'(1)) begin
                            state_reg <= TOP;
                        end else begin
                            i_reg <= i_reg + LEN_W'(1);
                        end
                    end
                end
                TOP: begin
                    if (j_reg == job_reg.yl - LEN_W'(1)) begin
                        zl_reg    <= (carry_reg == '0) ? tot - KW'(1) : tot;
                        k_reg     <= '0;
                        state_reg <= ERD;
                    end else begin
                        j_reg     <= j_reg + LEN_W'(1);
                        i_reg     <= '0;
                        carry_reg <= '0;
                        state_reg <= MUL;
                    end
                end
                ERD: begin
                    state_reg <= EWT;
                end
                EWT: begin
                    m_product_limb <= pd;
                    m_last_res     <= (k_reg == zl_reg - KW'(1));
                    m_overflow     <= job_reg.ovf;
                    m_valid        <= 1'b1;
                    state_reg      <= EOUT;
                end
                EOUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (k_reg == zl_reg - KW'(1)) begin
                            state_reg <= IDLE;
                        end else begin
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= ERD;
                        end
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    `MSM_ASSERT_IMPLY(a_mul_i_in_range, aclk, aresetn, state_reg == MUL, i_reg < job_reg.xl)
    `MSM_ASSERT_IMPLY(a_mul_j_in_range, aclk, aresetn, state_reg == MUL, j_reg < job_reg.yl)
    `MSM_ASSERT_IMPLY(a_valid_only_emit, aclk, aresetn, m_valid, state_reg == EOUT)
    `MSM_ASSERT_NEXT(a_pop_leaves_idle, aclk, aresetn, pop, state_reg != IDLE)
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// testbench for the multiword schoolbook multiplier: operand limb beats in,
// product limb beats out, checked limb by limb against a scoreboard predictor
// depends on msm_pkg and multiword_schoolbook_multiply
`timescale 1ns / 1ps
`default_nettype none

import msm_pkg::*;

typedef struct {
    logic [LIMB_W-1:0] limb;
    logic              last;
    logic              ovf;
} product_beat_t;

class product_scoreboard;
    localparam int DEPTH = MAX_LIMBS_DEF;

    logic [LIMB_W-1:0] x_limbs[DEPTH];
    logic [LIMB_W-1:0] y_limbs[DEPTH];
    int                x_len, y_len;
    bit                x_closed, y_closed, dropped;
    product_beat_t     pending_beats[$];
    int                errors, products, beats_out, longest;

    function new();
        x_len = 0;
        y_len = 0;
        x_closed = 0;
        y_closed = 0;
        dropped = 0;
        errors = 0;
        products = 0;
        beats_out = 0;
        longest = 0;
    endfunction

    function int pending();
        return pending_beats.size();
    endfunction

    // append one expected beat at the tail
    function void queue_beat(product_beat_t b);
        pending_beats = {pending_beats, b};
    endfunction

    // schoolbook product of the held operands, queued least significant first
    function void multiply();
        logic [LIMB_W-1:0]   prod[2*DEPTH];
        logic [2*LIMB_W-1:0] acc;
        logic [LIMB_W-1:0]   carry;
        product_beat_t       b;
        int                  n;
        products++;
        if (x_len == 0 || y_len == 0 || (x_len == 1 && x_limbs[0] == '0) ||
            (y_len == 1 && y_limbs[0] == '0)) begin
            b.limb = '0;
            b.last = 1'b1;
            b.ovf = dropped;
            queue_beat(b);
        end else begin
            for (int k = 0; k < 2 * DEPTH; k++) prod[k] = '0;
            carry = '0;
            for (int j = 0; j < y_len; j++) begin
                carry = '0;
                for (int i = 0; i < x_len; i++) begin
                    acc = {64'd0, x_limbs[i]} * {64'd0, y_limbs[j]}
                        + {64'd0, prod[i+j]} + {64'd0, carry};
                    prod[i+j] = acc[LIMB_W-1:0];
                    carry = acc[2*LIMB_W-1:LIMB_W];
                end
                prod[x_len+j] = carry;
            end
            n = x_len + y_len - ((carry == '0) ? 1 : 0);
            if (n > longest) longest = n;
            for (int k = 0; k < n; k++) begin
                b.limb = prod[k];
                b.last = (k == n - 1);
                b.ovf = dropped;
                queue_beat(b);
            end
        end
        x_len = 0;
        y_len = 0;
        x_closed = 0;
        y_closed = 0;
        dropped = 0;
    endfunction

    function void note_beat(logic cmd, logic [LIMB_W-1:0] limb, logic last);
        if (cmd == 1'b0) begin
            if (x_closed) begin
                x_len = 0;
                x_closed = 0;
            end
            if (x_len < DEPTH) x_limbs[x_len++] = limb;
            else dropped = 1;
            if (last) x_closed = 1;
        end else begin
            if (y_closed) begin
                y_len = 0;
                y_closed = 0;
            end
            if (y_len < DEPTH) y_limbs[y_len++] = limb;
            else dropped = 1;
            if (last) begin
                y_closed = 1;
                multiply();
            end
        end
    endfunction

    function void check_beat(logic [LIMB_W-1:0] limb, logic last, logic ovf);
        product_beat_t e;
        beats_out++;
        if (pending_beats.size() == 0) begin
            $display("%0t: unexpected product beat limb=%h last=%b ovf=%b",
                     $time, limb, last, ovf);
            errors++;
            return;
        end
        e = pending_beats.pop_front();
        if (limb !== e.limb) begin
            $display("%0t: product_limb expected %h actual %h", $time, e.limb, limb);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last_res expected %b actual %b", $time, e.last, last);
            errors++;
        end
        if (ovf !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int  RAND_BEATS  = 170;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam bit  CMD_X       = 1'b0;
    localparam bit  CMD_Y       = 1'b1;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [LIMB_W-1:0] s_limb;
    logic              s_last;
    logic              m_valid;
    logic              m_ready;
    logic [LIMB_W-1:0] m_product_limb;
    logic              m_last_res;
    logic              m_overflow;

    product_scoreboard sb;
    int  beats_in;
    int  burst_left;
    bit  hold_req;       // sender asks the receiver for a long hold-off
    int  cycles;

    multiword_schoolbook_multiply u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_limb        (s_limb),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_product_limb(m_product_limb),
        .m_last_res    (m_last_res),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // cycle counter doubles as the run watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d beats still expected",
                         cycles, sb.pending());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: stall pattern re-picked at random from four modes, plus one long hold-off
    initial begin
        int mode, phase, hold_cnt;
        bit held;
        mode = 0;
        phase = 0;
        hold_cnt = 0;
        held = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_beat(m_product_limb, m_last_res, m_overflow);
            if (hold_req && !held) begin
                held = 1;
                hold_cnt = 600;
            end
            phase++;
            if (phase == 64) begin
                phase = 0;
                mode = $urandom_range(0, 3);
            end
            if (hold_cnt > 0) begin
                // long hold-off, block backs up and stops taking limbs
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (phase[2:0] != 3'd0);
                endcase
            end
        end
    end

    // one beat with burst/gap shaping; called at a rising edge
    task automatic send_beat(input logic cmd, input logic [LIMB_W-1:0] limb,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_limb  <= limb;
        s_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(cmd, limb, last);
        beats_in++;
    endtask

    // random limb leaning on zero and all-ones now and then
    function automatic logic [LIMB_W-1:0] pick_limb();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_operand(input logic cmd, input int n, input logic close);
        for (int k = 0; k < n; k++)
            send_beat(cmd, pick_limb(), close && (k == n - 1));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return $urandom_range(30, 34);
        if (r < 10) return $urandom_range(5, 10);
        return $urandom_range(1, 4);
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int r;
        sb = new();
        beats_in = 0;
        burst_left = 0;
        hold_req = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = 1'b0;
        s_limb = '0;
        s_last = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and the special cases
        // empty first operand
        send_beat(CMD_Y, 64'd5, 1'b1);
        // single zero limb on each side
        send_beat(CMD_X, '0, 1'b1);
        send_beat(CMD_Y, '1, 1'b1);
        send_beat(CMD_X, '1, 1'b1);
        send_beat(CMD_Y, '0, 1'b1);
        // all-ones squared, two limbs each
        send_beat(CMD_X, '1, 1'b0);
        send_beat(CMD_X, '1, 1'b1);
        send_beat(CMD_Y, '1, 1'b0);
        send_beat(CMD_Y, '1, 1'b1);
        // small product, top limb zero is dropped
        send_beat(CMD_X, 64'd3, 1'b1);
        send_beat(CMD_Y, 64'd7, 1'b1);
        // leading zero limbs kept
        send_beat(CMD_X, 64'd1, 1'b0);
        send_beat(CMD_X, '0, 1'b1);
        send_beat(CMD_Y, '0, 1'b0);
        send_beat(CMD_Y, 64'd9, 1'b1);
        // closed first operand restarts on a new limb
        send_beat(CMD_X, 64'hdead_beef, 1'b1);
        send_beat(CMD_X, 64'h8000_0000_0000_0000, 1'b0);
        send_beat(CMD_X, 64'h1234_5678_9abc_def0, 1'b1);
        send_beat(CMD_Y, 64'h8000_0000_0000_0001, 1'b1);
        // second operand with no last, then first operand, then close
        send_beat(CMD_Y, 64'd2, 1'b0);
        send_beat(CMD_X, 64'd11, 1'b1);
        send_beat(CMD_Y, '1, 1'b1);
        drain();

        // random: well-formed products, some restarts and oversize operands
        while (beats_in < RAND_BEATS + 22) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: an abandoned first operand
                send_operand(CMD_X, pick_len(), $urandom_range(0, 1) == 1);
            end else if (r < 12) begin
                send_operand(CMD_Y, pick_len(), 1'b1);
            end else begin
                send_operand(CMD_X, pick_len(), $urandom_range(0, 7) != 0);
                send_operand(CMD_Y, pick_len(), 1'b1);
            end
            if (!hold_req && beats_in > 120) hold_req = 1;
            if ($urandom_range(0, 19) == 0) drain();
        end
        // one full-size product and two overflowing pairs
        send_operand(CMD_X, 32, 1'b1);
        send_operand(CMD_Y, 32, 1'b1);
        send_operand(CMD_X, 33, 1'b1);
        send_operand(CMD_Y, 2, 1'b1);
        send_operand(CMD_X, 3, 1'b1);
        send_operand(CMD_Y, 34, 1'b1);
        drain();
        repeat (50) @(posedge aclk);

        $display("sent %0d limb beats, %0d products, %0d product beats checked",
                 beats_in, sb.products, sb.beats_out);
        $display("longest product %0d limbs, %0d cycles", sb.longest, cycles);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
